// ===== rtl/tdc_hit_stream_unpacker_macros.svh =====
// Assertion macros used by the checker file.
`ifndef TDC_HIT_STREAM_UNPACKER_MACROS_SVH
`define TDC_HIT_STREAM_UNPACKER_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define THU_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define THU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ===== rtl/thsu_pkg.sv =====
// ----------------------------------------------------------------------------
// thsu_pkg: shared types and constants of the TDC hit stream unpacker
// Holds parse phases, result kinds, register indexes and field widths.
// ----------------------------------------------------------------------------
package thsu_pkg;

  localparam int unsigned DEF_MAX_PACKET_WORDS = 16384;
  localparam int unsigned DEF_HEADER_WORDS     = 6;
  localparam int unsigned DEF_TRAILER_WORDS    = 11;
  localparam int unsigned DEF_NUM_ENDPOINTS    = 4;
  localparam int unsigned DEF_NUM_HUBS         = 2;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned PLEN_W     = 15;

  typedef enum logic [2:0] {
    PH_ADDR     = 3'd0,
    PH_SKIP     = 3'd1,
    PH_CTS_HDR  = 3'd2,
    PH_CTS_BODY = 3'd3,
    PH_TDC_HDR  = 3'd4,
    PH_TDC_BODY = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    CH_NONE  = 2'd0,
    CH_EPOCH = 2'd1,
    CH_VALID = 2'd2
  } chmode_t;

  typedef enum logic [1:0] {
    KIND_HIT     = 2'd0,
    KIND_TRIGGER = 2'd1,
    KIND_BAD_HDR = 2'd2,
    KIND_END     = 2'd3
  } kind_t;

  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_ADDR = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HUB_A        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HUB_B        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EP_0         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_EP_1         = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_EP_2         = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_EP_3         = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE_MASK  = 3'd7;

  localparam logic [2:0] TDC_HDR_CODE   = 3'b001;
  localparam logic [2:0] TDC_EPOCH_CODE = 3'b011;
  localparam logic [2:0] TDC_DEBUG_CODE = 3'b010;

endpackage

// ===== rtl/tdc_hit_stream_unpacker.sv =====
// ----------------------------------------------------------------------------
// tdc_hit_stream_unpacker: TDC packet word decoder
// Walks the block structure of a readout packet, one 32-bit word at a time,
// and emits hits, external triggers, header errors and packet end status.
// ----------------------------------------------------------------------------
//  channel   | signals                                  | direction
//  ----------+------------------------------------------+----------
//  input     | in_valid, in_stall, data_word, ...       | in
//  result    | out_valid, out_stall, result_kind, ...   | out
//  config    | cfg_we, cfg_index, cfg_data              | in
//
// Each word is decoded in the cycle it is accepted; its result (if any)
// appears in the output register on the next cycle. One transaction per cycle,
// unless stalled; the input is stalled only while a result waits in the output
// register and the result side stalls. Reset (rst, synchronous) clears the parse
// state and config (trigger address set to all ones); no clearing pass.
module tdc_hit_stream_unpacker
  import thsu_pkg::*;
#(
  parameter int unsigned MAX_PACKET_WORDS = DEF_MAX_PACKET_WORDS,
  parameter int unsigned HEADER_WORDS     = DEF_HEADER_WORDS,
  parameter int unsigned TRAILER_WORDS    = DEF_TRAILER_WORDS,
  parameter int unsigned NUM_ENDPOINTS    = DEF_NUM_ENDPOINTS,
  parameter int unsigned NUM_HUBS         = DEF_NUM_HUBS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [31:0]           data_word,
  input  logic [14:0]           packet_length,
  input  logic                  first_word,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            result_kind,
  output logic [15:0]           source_address,
  output logic [6:0]            channel,
  output logic [9:0]            fine_time,
  output logic                  rising_edge,
  output logic [10:0]           coarse_time,
  output logic [27:0]           epoch,
  output logic                  is_reference,
  output logic [31:0]           trigger_number,
  output logic [31:0]           trigger_status,
  output logic                  no_trigger_block,
  output logic                  overrun
);

  localparam logic [14:0] MAXW = 15'(MAX_PACKET_WORDS > 32767 ? 32767 : MAX_PACKET_WORDS);
  localparam logic [14:0] HDRW = 15'(HEADER_WORDS);
  localparam logic [14:0] TRLW = 15'(TRAILER_WORDS);

  // Configuration registers.
  logic [15:0] trig_addr;
  logic [15:0] hub_addr [2];
  logic [15:0] ep_addr  [4];
  logic [5:0]  en_mask;

  // Parse state.
  phase_t      phase, phase_next;
  logic [14:0] word_pos, word_pos_next;
  logic [14:0] pkt_len, pkt_len_next;
  logic [15:0] blk_left, blk_left_next;
  logic [15:0] blk_total, blk_total_next;
  logic [7:0]  trg_left, trg_left_next;
  logic [1:0]  ext_mode, ext_mode_next;
  logic [15:0] blk_addr, blk_addr_next;
  logic [27:0] epoch_cnt, epoch_cnt_next;
  logic [6:0]  prev_ch, prev_ch_next;
  chmode_t     prev_mode, prev_mode_next;
  logic        trg_seen, trg_seen_next;
  logic [31:0] trg_num, trg_num_next;

  logic        fire;
  logic        res_valid;
  kind_t       res_kind;
  logic [15:0] res_src;
  logic [6:0]  res_ch;
  logic [9:0]  res_fine;
  logic        res_rise;
  logic [10:0] res_coarse;
  logic [27:0] res_epoch;
  logic        res_ref;
  logic [31:0] res_tnum, res_tstat;
  logic        res_notrg, res_ovr;

  assign in_stall = out_valid & out_stall;
  assign fire     = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      trig_addr   <= 16'hFFFF;
      hub_addr[0] <= '0;
      hub_addr[1] <= '0;
      for (int k = 0; k < 4; k++) ep_addr[k] <= '0;
      en_mask     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TRIGGER_ADDR: trig_addr   <= cfg_data;
        REG_HUB_A:        hub_addr[0] <= cfg_data;
        REG_HUB_B:        hub_addr[1] <= cfg_data;
        REG_EP_0:         ep_addr[0]  <= cfg_data;
        REG_EP_1:         ep_addr[1]  <= cfg_data;
        REG_EP_2:         ep_addr[2]  <= cfg_data;
        REG_EP_3:         ep_addr[3]  <= cfg_data;
        default:          en_mask     <= cfg_data[5:0];
      endcase
    end
  end

  // Block decode helpers.
  logic [15:0] w_addr, w_len;
  logic        hit_hub, hit_ep;
  logic [2:0]  top3;
  logic [6:0]  w_ch;
  logic [1:0]  cts_flag;
  logic [7:0]  cts_base, cts_total;
  logic [14:0] pay_end, len_eff;
  logic        in_pkt, in_payload, last_word, ovr;

  assign w_addr   = data_word[15:0];
  assign w_len    = data_word[31:16];
  assign top3     = data_word[31:29];
  assign w_ch     = data_word[28:22];
  assign cts_flag = data_word[29:28];

  always_comb begin
    hit_hub = 1'b0;
    hit_ep  = 1'b0;
    for (int k = 0; k < 2; k++)
      if (k < NUM_HUBS && en_mask[k] && hub_addr[k] == w_addr) hit_hub = 1'b1;
    for (int k = 0; k < 4; k++)
      if (k < NUM_ENDPOINTS && en_mask[2+k] && ep_addr[k] == w_addr) hit_ep = 1'b1;
  end

  // Trigger header: at most 1+30+30+2+3+1+4 = 71 words, fits in 8 bits.
  assign cts_base = 8'd1 + {3'd0, data_word[19:16], 1'b0} + {3'd0, data_word[23:20], 1'b0}
                  + {6'd0, data_word[25], 1'b0} + (data_word[26] ? 8'd3 : 8'd0)
                  + {7'd0, data_word[27]};
  always_comb begin
    unique case (cts_flag)
      2'd1:    cts_total = cts_base + 8'd1;
      2'd2:    cts_total = cts_base + 8'd4;
      2'd3:    cts_total = 8'd0;
      default: cts_total = cts_base;
    endcase
  end

  always_comb begin
    phase_next     = phase;
    word_pos_next  = word_pos;
    pkt_len_next   = pkt_len;
    blk_left_next  = blk_left;
    blk_total_next = blk_total;
    trg_left_next  = trg_left;
    ext_mode_next  = ext_mode;
    blk_addr_next  = blk_addr;
    epoch_cnt_next = epoch_cnt;
    prev_ch_next   = prev_ch;
    prev_mode_next = prev_mode;
    trg_seen_next  = trg_seen;
    trg_num_next   = trg_num;
    res_valid  = 1'b0;
    res_kind   = KIND_HIT;
    res_src    = '0;
    res_ch     = '0;
    res_fine   = '0;
    res_rise   = 1'b0;
    res_coarse = '0;
    res_epoch  = '0;
    res_ref    = 1'b0;
    res_tnum   = '0;
    res_tstat  = '0;
    res_notrg  = 1'b0;
    res_ovr    = 1'b0;

    // A first word restarts the walk before anything else is looked at.
    len_eff = (packet_length > MAXW) ? MAXW : packet_length;
    if (first_word) begin
      pkt_len_next   = len_eff;
      word_pos_next  = '0;
      phase_next     = PH_ADDR;
      blk_left_next  = '0;
      blk_total_next = '0;
      trg_left_next  = '0;
      ext_mode_next  = '0;
      trg_seen_next  = 1'b0;
    end
    in_pkt     = word_pos_next < pkt_len_next;
    pay_end    = (pkt_len_next > TRLW) ? pkt_len_next - TRLW : '0;
    in_payload = in_pkt && word_pos_next >= HDRW && word_pos_next < pay_end;
    last_word  = in_pkt && (word_pos_next + 15'd1 == pkt_len_next);

    if (in_pkt) word_pos_next = word_pos_next + 15'd1;

    if (in_payload) begin
      unique case (phase_next)
        PH_ADDR: begin
          blk_addr_next = w_addr;
          if (w_addr == trig_addr) begin
            trg_seen_next  = 1'b1;
            blk_total_next = w_len;
            phase_next     = (w_len != 0) ? PH_CTS_HDR : PH_ADDR;
          end else if (hit_hub) begin
            phase_next = PH_ADDR;
          end else begin
            blk_left_next = w_len;
            if (hit_ep) phase_next = (w_len != 0) ? PH_TDC_HDR : PH_ADDR;
            else        phase_next = (w_len != 0) ? PH_SKIP : PH_ADDR;
          end
        end
        PH_SKIP: begin
          blk_left_next = blk_left_next - 16'd1;
          if (blk_left_next == 0) phase_next = PH_ADDR;
        end
        PH_CTS_HDR: begin
          if (cts_total == 0 || {8'd0, cts_total} > blk_total_next) begin
            blk_left_next = blk_total_next - 16'd1;
            phase_next    = (blk_left_next != 0) ? PH_SKIP : PH_ADDR;
          end else begin
            ext_mode_next = cts_flag;
            trg_left_next = cts_total - 8'd1;
            blk_left_next = blk_total_next - {8'd0, cts_total};
            if (trg_left_next == 0)
              phase_next = (blk_left_next != 0) ? PH_TDC_HDR : PH_ADDR;
            else
              phase_next = PH_CTS_BODY;
          end
        end
        PH_CTS_BODY: begin
          if (ext_mode == 2'd1 && trg_left == 8'd1) begin
            res_valid = 1'b1;
            res_kind  = KIND_TRIGGER;
            res_src   = blk_addr;
            res_tnum  = {8'd0, data_word[23:0]};
            res_tstat = {data_word[31:24], 24'd0};
          end else if (ext_mode == 2'd2 && trg_left == 8'd4) begin
            trg_num_next = data_word;
          end else if (ext_mode == 2'd2 && trg_left == 8'd3) begin
            res_valid = 1'b1;
            res_kind  = KIND_TRIGGER;
            res_src   = blk_addr;
            res_tnum  = trg_num;
            res_tstat = data_word;
          end
          trg_left_next = trg_left - 8'd1;
          if (trg_left_next == 0)
            phase_next = (blk_left != 0) ? PH_TDC_HDR : PH_ADDR;
        end
        PH_TDC_HDR: begin
          blk_left_next = blk_left - 16'd1;
          if (top3 == TDC_HDR_CODE) begin
            prev_mode_next = CH_NONE;
            phase_next     = (blk_left_next != 0) ? PH_TDC_BODY : PH_ADDR;
          end else begin
            res_valid  = 1'b1;
            res_kind   = KIND_BAD_HDR;
            res_src    = blk_addr;
            phase_next = (blk_left_next != 0) ? PH_SKIP : PH_ADDR;
          end
        end
        PH_TDC_BODY: begin
          if (top3 == TDC_EPOCH_CODE) begin
            epoch_cnt_next = data_word[27:0];
            prev_mode_next = CH_EPOCH;
          end else if (top3 != TDC_DEBUG_CODE && data_word[31]) begin
            if (prev_mode == CH_VALID && w_ch != prev_ch) epoch_cnt_next = '0;
            res_valid      = 1'b1;
            res_kind       = KIND_HIT;
            res_src        = blk_addr;
            res_ch         = w_ch;
            res_fine       = data_word[21:12];
            res_rise       = data_word[11];
            res_coarse     = data_word[10:0];
            res_epoch      = epoch_cnt_next;
            res_ref        = (w_ch == 7'd0) || (blk_addr == trig_addr);
            prev_ch_next   = w_ch;
            prev_mode_next = CH_VALID;
          end
          blk_left_next = blk_left - 16'd1;
          if (blk_left_next == 0) phase_next = PH_ADDR;
        end
        default: phase_next = PH_ADDR;
      endcase
    end

    ovr = phase_next == PH_SKIP || phase_next == PH_CTS_HDR || phase_next == PH_CTS_BODY;
    if (last_word) begin
      res_valid  = 1'b1;
      res_kind   = KIND_END;
      res_src    = '0;
      res_ch     = '0;
      res_fine   = '0;
      res_rise   = 1'b0;
      res_coarse = '0;
      res_epoch  = '0;
      res_ref    = 1'b0;
      res_tnum   = '0;
      res_tstat  = '0;
      res_notrg  = ~trg_seen_next;
      res_ovr    = ovr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_ADDR;
      word_pos  <= '0;
      pkt_len   <= '0;
      blk_left  <= '0;
      blk_total <= '0;
      trg_left  <= '0;
      ext_mode  <= '0;
      blk_addr  <= '0;
      epoch_cnt <= '0;
      prev_ch   <= '0;
      prev_mode <= CH_NONE;
      trg_seen  <= 1'b0;
      trg_num   <= '0;
    end else if (fire) begin
      phase     <= phase_next;
      word_pos  <= word_pos_next;
      pkt_len   <= pkt_len_next;
      blk_left  <= blk_left_next;
      blk_total <= blk_total_next;
      trg_left  <= trg_left_next;
      ext_mode  <= ext_mode_next;
      blk_addr  <= blk_addr_next;
      epoch_cnt <= epoch_cnt_next;
      prev_ch   <= prev_ch_next;
      prev_mode <= prev_mode_next;
      trg_seen  <= trg_seen_next;
      trg_num   <= trg_num_next;
    end
  end

  // Output register: loads whenever it is empty or being taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!in_stall) begin
      out_valid <= fire & res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && fire && res_valid) begin
      result_kind      <= res_kind;
      source_address   <= res_src;
      channel          <= res_ch;
      fine_time        <= res_fine;
      rising_edge      <= res_rise;
      coarse_time      <= res_coarse;
      epoch            <= res_epoch;
      is_reference     <= res_ref;
      trigger_number   <= res_tnum;
      trigger_status   <= res_tstat;
      no_trigger_block <= res_notrg;
      overrun          <= res_ovr;
    end
  end

endmodule

// ===== rtl/thsu_checker.sv =====
// ----------------------------------------------------------------------------
// thsu_checker: port-level assertions for the TDC hit stream unpacker
// Checks handshake behavior and result field consistency.
// ----------------------------------------------------------------------------
`include "tdc_hit_stream_unpacker_macros.svh"
module thsu_checker
  import thsu_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  result_kind,
  input logic [15:0] source_address,
  input logic [6:0]  channel,
  input logic        no_trigger_block,
  input logic        overrun
);
  `THU_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(result_kind), "stalled result changed")
  `THU_ASSERT_IMPL(a_stall_only_when_full, clk, rst, in_stall, out_valid && out_stall, "input stalled without a waiting result")
  `THU_ASSERT_IMPL(a_end_clean, clk, rst, out_valid && result_kind == KIND_END, source_address == 16'd0 && channel == 7'd0, "end status carries block fields")
  `THU_ASSERT_IMPL(a_status_only_end, clk, rst, out_valid && result_kind != KIND_END, !no_trigger_block && !overrun, "status bits outside end status")
endmodule

bind tdc_hit_stream_unpacker thsu_checker u_thsu_checker (
  .clk(clk), .rst(rst), .in_stall(in_stall), .out_valid(out_valid),
  .out_stall(out_stall), .result_kind(result_kind), .source_address(source_address),
  .channel(channel), .no_trigger_block(no_trigger_block), .overrun(overrun)
);
